// ----- rtl/byte_range_sector_splitter_core_macros.svh -----
// assertion macros for the byte range sector splitter
// included by rtl files that carry assertions; no other dependencies
`ifndef BYTE_RANGE_SECTOR_SPLITTER_CORE_MACROS_SVH
`define BYTE_RANGE_SECTOR_SPLITTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define BSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bss assertion failed");

// next-cycle implication, disabled during reset
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bss assertion failed");

`else

`define BSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/bss_pkg.sv -----
// shared constants and the transfer descriptor type for the sector splitter
// no dependencies
`default_nettype none

package bss_pkg;

    localparam int MAX_REQUEST_SECTORS = 64;
    localparam int BASE_SECTOR         = 512;

    localparam int OFF_W  = 48;
    localparam int LEN_W  = 15;
    localparam int SEC_W  = 39;
    localparam int WS_W   = 12;
    localparam int WB_W   = 13;
    localparam int LG_W   = 4;
    localparam int CNT_W  = $clog2(MAX_REQUEST_SECTORS + 1);
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;

    localparam logic [LEN_W-1:0] MAX_LEN =
        LEN_W'((MAX_REQUEST_SECTORS - 2) * BASE_SECTOR);

    localparam logic [LG_W-1:0] LG_MIN   = 4'd9;
    localparam logic [LG_W-1:0] LG_MAX   = 4'd12;
    localparam logic [LG_W-1:0] LG_RESET = 4'd9;

    // register index is paddr[3]
    localparam logic REG_SECTOR_SIZE_LOG2 = 1'b0;
    localparam logic REG_CAPACITY         = 1'b1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic                 empty;
        logic                 head;
        logic                 tail;
        logic [CNT_W-1:0]     whole_cnt;
        logic [SEC_W-1:0]     head_sec;
        logic [WS_W-1:0]      head_ws;
        logic [WB_W-1:0]      head_wb;
        logic [SEC_W-1:0]     tail_sec;
        logic [WS_W-1:0]      tail_wb;
        logic [LEN_W-1:0]     tail_bp;
        logic [SEC_W-1:0]     whole_sec;
        logic [LEN_W-1:0]     whole_bp;
        logic [WB_W-1:0]      ssz;
        logic [LEN_W-1:0]     total;
    } desc_t;

endpackage

`default_nettype wire

// ----- rtl/bss_front.sv -----
// front end: accepts a request, clips it and classifies head, tail and whole sectors
// depends on bss_pkg and the assertion macro header
`default_nettype none
`include "byte_range_sector_splitter_core_macros.svh"

module bss_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [bss_pkg::OFF_W-1:0]     byte_offset,
    input  wire logic [bss_pkg::LEN_W-1:0]     byte_length,
    input  wire logic [bss_pkg::LG_W-1:0]      cfg_lg,
    input  wire logic [bss_pkg::OFF_W-1:0]     cfg_cap,
    output logic                               desc_valid,
    input  wire logic                          desc_ready,
    output bss_pkg::desc_t                     desc
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CLIP  = 2'd1;
    localparam logic [1:0] F_SPLIT = 2'd2;

    logic [1:0]                    fstate_reg, fstate_next;
    logic                          cmd_reg;
    logic [bss_pkg::OFF_W-1:0]     off_reg;
    logic [bss_pkg::LEN_W-1:0]     len_reg;
    logic [bss_pkg::LG_W-1:0]      lg_reg;
    logic [bss_pkg::LEN_W-1:0]     n_reg, n_next;
    logic [bss_pkg::OFF_W-1:0]     end_reg, end_next;
    logic [bss_pkg::LG_W-1:0]      lg_clamp;

    // clip stage
    logic [bss_pkg::OFF_W:0]       sum;
    logic [bss_pkg::OFF_W-1:0]     room;
    logic                          over_cap, too_long, clip;

    // split stage
    logic [bss_pkg::WB_W-1:0]      ssz;
    logic [bss_pkg::WS_W-1:0]      smask, inoff, tailb;
    logic [bss_pkg::OFF_W-1:0]     start48, endm1, last48;
    logic [bss_pkg::SEC_W-1:0]     start_sec, last_sec;
    logic [bss_pkg::CNT_W-1:0]     span;
    logic [bss_pkg::WB_W-1:0]      pre_full, pre;
    logic                          head, tail;

    always_comb
    begin
        if (cfg_lg < bss_pkg::LG_MIN)
        begin
            lg_clamp = bss_pkg::LG_MIN;
        end
        else if (cfg_lg > bss_pkg::LG_MAX)
        begin
            lg_clamp = bss_pkg::LG_MAX;
        end
        else
        begin
            lg_clamp = cfg_lg;
        end
    end

    assign in_ready = (fstate_reg == F_IDLE);

    always_comb
    begin
        sum      = {1'b0, off_reg} + (bss_pkg::OFF_W + 1)'(len_reg);
        room     = cfg_cap - off_reg;
        over_cap = off_reg > cfg_cap;
        too_long = len_reg > bss_pkg::MAX_LEN;
        clip     = sum > {1'b0, cfg_cap};
        if (over_cap || too_long)
        begin
            n_next = '0;
        end
        else if (clip)
        begin
            n_next = room[bss_pkg::LEN_W-1:0];
        end
        else
        begin
            n_next = len_reg;
        end
        end_next = clip ? cfg_cap : sum[bss_pkg::OFF_W-1:0];
    end

    always_comb
    begin
        ssz       = bss_pkg::WB_W'(1) << lg_reg;
        smask     = bss_pkg::WS_W'(ssz - bss_pkg::WB_W'(1));
        inoff     = off_reg[bss_pkg::WS_W-1:0] & smask;
        tailb     = end_reg[bss_pkg::WS_W-1:0] & smask;
        start48   = off_reg >> lg_reg;
        endm1     = end_reg - bss_pkg::OFF_W'(1);
        last48    = endm1 >> lg_reg;
        start_sec = start48[bss_pkg::SEC_W-1:0];
        last_sec  = last48[bss_pkg::SEC_W-1:0];
        // sector span of one request is small, low bits suffice
        span      = last_sec[bss_pkg::CNT_W-1:0] - start_sec[bss_pkg::CNT_W-1:0];
        pre_full  = ssz - {1'b0, inoff};
        if (bss_pkg::LEN_W'(pre_full) > n_reg)
        begin
            pre = n_reg[bss_pkg::WB_W-1:0];
        end
        else
        begin
            pre = pre_full;
        end
        head = (inoff != '0) || (!cmd_reg && (bss_pkg::LEN_W'(ssz) > n_reg));
        tail = (tailb != '0) && !(head && (span == '0));

        desc.empty     = (n_reg == '0);
        desc.head      = head;
        desc.tail      = tail;
        desc.whole_cnt = span + bss_pkg::CNT_W'(1) - bss_pkg::CNT_W'(head)
                         - bss_pkg::CNT_W'(tail);
        desc.head_sec  = start_sec;
        desc.head_ws   = inoff;
        desc.head_wb   = pre;
        desc.tail_sec  = last_sec;
        desc.tail_wb   = tailb;
        desc.tail_bp   = n_reg - bss_pkg::LEN_W'(tailb);
        desc.whole_sec = start_sec + bss_pkg::SEC_W'(head);
        desc.whole_bp  = head ? bss_pkg::LEN_W'(pre) : '0;
        desc.ssz       = ssz;
        desc.total     = n_reg;
    end

    assign desc_valid = (fstate_reg == F_SPLIT);

    always_comb
    begin
        fstate_next = fstate_reg;
        unique case (fstate_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    fstate_next = F_CLIP;
                end
            end
            F_CLIP:
            begin
                fstate_next = F_SPLIT;
            end
            F_SPLIT:
            begin
                if (desc_ready)
                begin
                    fstate_next = F_IDLE;
                end
            end
            default:
            begin
                fstate_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg <= F_IDLE;
        end
        else
        begin
            fstate_reg <= fstate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            off_reg <= byte_offset;
            len_reg <= byte_length;
            lg_reg  <= lg_clamp;
        end
        if (fstate_reg == F_CLIP)
        begin
            n_reg   <= n_next;
            end_reg <= end_next;
        end
    end

    `BSS_ASSERT_IMPL(a_front_n_bounded, clk, rst_n, fstate_reg == F_SPLIT, n_reg <= len_reg)
    `BSS_ASSERT_IMPL(a_front_some_result, clk, rst_n, (fstate_reg == F_SPLIT) && (n_reg != '0), desc.head || desc.tail || (desc.whole_cnt != '0))

endmodule

`default_nettype wire

// ----- rtl/bss_fifo.sv -----
// short descriptor queue between the front end and the back end
// depends on bss_pkg
`default_nettype none

module bss_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire bss_pkg::desc_t    wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output bss_pkg::desc_t         rd_data
);

    bss_pkg::desc_t                    mem_reg [bss_pkg::FIFO_DEPTH];
    logic [bss_pkg::FIFO_PTR_W-1:0]    wptr_reg, rptr_reg;
    logic [bss_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic                              push, pop;

    assign wr_ready = (count_reg != bss_pkg::FIFO_CNT_W'(bss_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + bss_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + bss_pkg::FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + bss_pkg::FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - bss_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bss_back.sv -----
// back end: walks one descriptor and emits one sector transfer per cycle while out_ready is high
// depends on bss_pkg and the assertion macro header
`default_nettype none
`include "byte_range_sector_splitter_core_macros.svh"

module bss_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          desc_valid,
    output logic                               desc_ready,
    input  wire bss_pkg::desc_t                desc,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bss_pkg::SEC_W-1:0]          sector_index,
    output logic [bss_pkg::WS_W-1:0]           window_start,
    output logic [bss_pkg::WB_W-1:0]           window_bytes,
    output logic [bss_pkg::LEN_W-1:0]          buffer_position,
    output logic                               partial,
    output logic [bss_pkg::LEN_W-1:0]          clipped_total,
    output logic                               last
);

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_HEAD  = 2'd1;
    localparam logic [1:0] PH_TAIL  = 2'd2;
    localparam logic [1:0] PH_WHOLE = 2'd3;

    logic                          busy_reg;
    logic [1:0]                    phase_reg, phase_next;
    bss_pkg::desc_t                cur_reg;
    logic [bss_pkg::SEC_W-1:0]     wsec_reg;
    logic [bss_pkg::LEN_W-1:0]     wbp_reg;
    logic [bss_pkg::CNT_W-1:0]     wcnt_reg;

    logic                          out_valid_reg;
    logic [bss_pkg::SEC_W-1:0]     sec_reg, sec_next;
    logic [bss_pkg::WS_W-1:0]      ws_reg, ws_next;
    logic [bss_pkg::WB_W-1:0]      wb_reg, wb_next;
    logic [bss_pkg::LEN_W-1:0]     bp_reg, bp_next;
    logic                          part_reg, part_next;
    logic [bss_pkg::LEN_W-1:0]     total_reg;
    logic                          last_reg, done;

    logic                          emit, load;
    logic [1:0]                    load_phase;

    assign emit       = busy_reg && (!out_valid_reg || out_ready);
    assign load       = !busy_reg && desc_valid;
    assign desc_ready = !busy_reg;

    always_comb
    begin
        if (desc.empty)
        begin
            load_phase = PH_EMPTY;
        end
        else if (desc.head)
        begin
            load_phase = PH_HEAD;
        end
        else if (desc.tail)
        begin
            load_phase = PH_TAIL;
        end
        else
        begin
            load_phase = PH_WHOLE;
        end
    end

    always_comb
    begin
        sec_next   = '0;
        ws_next    = '0;
        wb_next    = '0;
        bp_next    = '0;
        part_next  = 1'b0;
        done       = 1'b1;
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_EMPTY:
            begin
                done = 1'b1;
            end
            PH_HEAD:
            begin
                sec_next   = cur_reg.head_sec;
                ws_next    = cur_reg.head_ws;
                wb_next    = cur_reg.head_wb;
                part_next  = 1'b1;
                done       = !cur_reg.tail && (wcnt_reg == '0);
                phase_next = cur_reg.tail ? PH_TAIL : PH_WHOLE;
            end
            PH_TAIL:
            begin
                sec_next   = cur_reg.tail_sec;
                wb_next    = bss_pkg::WB_W'(cur_reg.tail_wb);
                bp_next    = cur_reg.tail_bp;
                part_next  = 1'b1;
                done       = (wcnt_reg == '0);
                phase_next = PH_WHOLE;
            end
            PH_WHOLE:
            begin
                sec_next   = wsec_reg;
                wb_next    = cur_reg.ssz;
                bp_next    = wbp_reg;
                done       = (wcnt_reg == bss_pkg::CNT_W'(1));
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= load_phase;
            end
            else if (emit)
            begin
                phase_reg <= phase_next;
                if (done)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg  <= desc;
            wsec_reg <= desc.whole_sec;
            wbp_reg  <= desc.whole_bp;
            wcnt_reg <= desc.whole_cnt;
        end
        else if (emit && (phase_reg == PH_WHOLE))
        begin
            wsec_reg <= wsec_reg + bss_pkg::SEC_W'(1);
            wbp_reg  <= wbp_reg + bss_pkg::LEN_W'(cur_reg.ssz);
            wcnt_reg <= wcnt_reg - bss_pkg::CNT_W'(1);
        end
        if (emit)
        begin
            sec_reg   <= sec_next;
            ws_reg    <= ws_next;
            wb_reg    <= wb_next;
            bp_reg    <= bp_next;
            part_reg  <= part_next;
            total_reg <= cur_reg.total;
            last_reg  <= done;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sector_index    = sec_reg;
    assign window_start    = ws_reg;
    assign window_bytes    = wb_reg;
    assign buffer_position = bp_reg;
    assign partial         = part_reg;
    assign clipped_total   = total_reg;
    assign last            = last_reg;

    `BSS_ASSERT_IMPL(a_back_whole_nonzero, clk, rst_n, busy_reg && (phase_reg == PH_WHOLE), wcnt_reg != '0)
    `BSS_ASSERT_IMPL(a_back_empty_total, clk, rst_n, busy_reg && (phase_reg == PH_EMPTY), cur_reg.total == '0)

endmodule

`default_nettype wire

// ----- rtl/byte_range_sector_splitter_core.sv -----
// top level of the byte range sector splitter: config registers, front end, queue, back end
// depends on bss_pkg, bss_front, bss_fifo and bss_back
//
//  channel   direction  signals                                     accepted when
//  request   in         in_valid/in_ready, cmd, byte_offset, len    in_valid & in_ready
//  transfer  out        out_valid/out_ready, sector fields, last    out_valid & out_ready
//  config    in         psel/penable/pwrite/paddr/pwdata/prdata     psel & penable & pwrite
//
// the front end takes one item at a time through capture, 48-bit clip and sector split,
// and takes no new request until the split result is accepted; the back end loads a
// descriptor, then emits one transfer per cycle while out_ready is high
// reset sets sector_size_log2 to 9, capacity_bytes to 0 and empties the queue
// out_ready low holds the output register; the queue then fills and in_ready drops
`default_nettype none

module byte_range_sector_splitter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bss_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bss_pkg::DATA_W-1:0]    pwdata,
    output logic [bss_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [bss_pkg::OFF_W-1:0]     byte_offset,
    input  wire logic [bss_pkg::LEN_W-1:0]     byte_length,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bss_pkg::SEC_W-1:0]          sector_index,
    output logic [bss_pkg::WS_W-1:0]           window_start,
    output logic [bss_pkg::WB_W-1:0]           window_bytes,
    output logic [bss_pkg::LEN_W-1:0]          buffer_position,
    output logic                               partial,
    output logic [bss_pkg::LEN_W-1:0]          clipped_total,
    output logic                               last
);

    logic [bss_pkg::LG_W-1:0]      lg_reg;
    logic [bss_pkg::OFF_W-1:0]     cap_reg;
    logic                          cfg_wr;
    logic                          reg_sel;

    logic                          f_valid, f_ready, b_valid, b_ready;
    bss_pkg::desc_t                f_desc, b_desc;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_sel)
            bss_pkg::REG_SECTOR_SIZE_LOG2:
            begin
                prdata = bss_pkg::DATA_W'(lg_reg);
            end
            bss_pkg::REG_CAPACITY:
            begin
                prdata = bss_pkg::DATA_W'(cap_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_reg  <= bss_pkg::LG_RESET;
            cap_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == bss_pkg::REG_SECTOR_SIZE_LOG2)
            begin
                lg_reg <= pwdata[bss_pkg::LG_W-1:0];
            end
            else
            begin
                cap_reg <= pwdata[bss_pkg::OFF_W-1:0];
            end
        end
    end

    bss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .byte_offset (byte_offset),
        .byte_length (byte_length),
        .cfg_lg      (lg_reg),
        .cfg_cap     (cap_reg),
        .desc_valid  (f_valid),
        .desc_ready  (f_ready),
        .desc        (f_desc)
    );

    bss_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_desc),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_desc)
    );

    bss_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .desc_valid      (b_valid),
        .desc_ready      (b_ready),
        .desc            (b_desc),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sector_index    (sector_index),
        .window_start    (window_start),
        .window_bytes    (window_bytes),
        .buffer_position (buffer_position),
        .partial         (partial),
        .clipped_total   (clipped_total),
        .last            (last)
    );

endmodule

`default_nettype wire
